>>> rtl/core/cau_pkg.sv
`default_nettype none

package cau_pkg;

   // operand and result format
   localparam int unsigned Q_W    = 16;
   localparam int unsigned WIDE_W = 34;   // signed width that holds every raw result

   // divider lanes
   localparam int unsigned DEN_W = 32;            // b_re^2 + b_im^2
   localparam int unsigned REM_W = 40;            // |numerator| * 256
   localparam int unsigned QUO_W = 17;            // quotient bits kept before saturation
   localparam int unsigned CMP_W = DEN_W + QUO_W; // shifted divisor

   // square root lane
   localparam int unsigned SQ_W   = 32;
   localparam int unsigned ROOT_W = 16;
   localparam int unsigned SQT_W  = 34;

   // one step for the range check, then one per quotient bit
   localparam int unsigned STEPS = QUO_W + 1;

   localparam logic signed [WIDE_W-1:0] Q_MAX = 34'sd32767;
   localparam logic signed [WIDE_W-1:0] Q_MIN = -34'sd32768;

   typedef enum logic [2:0] {
      ACT_ADD = 3'd0,
      ACT_SUB = 3'd1,
      ACT_MUL = 3'd2,
      ACT_DIV = 3'd3,
      ACT_MAG = 3'd4
   } action_type;

   typedef struct packed {
      logic               valid;
      action_type         action;
      logic [Q_W-1:0]     fast_re;    // add, subtract, multiply results, saturated
      logic [Q_W-1:0]     fast_im;
      logic               fast_ovf;
      logic               dz;
      logic               neg_re;
      logic               neg_im;
      logic               pre_ovf_re;
      logic               pre_ovf_im;
      logic [REM_W-1:0]   r_re;
      logic [REM_W-1:0]   r_im;
      logic [QUO_W-1:0]   q_re;
      logic [QUO_W-1:0]   q_im;
      logic [DEN_W-1:0]   den;
      logic [SQ_W-1:0]    sq_rem;
      logic [ROOT_W-1:0]  root;
   } pipe_type;

   typedef struct packed {
      logic           ovf;
      logic [Q_W-1:0] val;
   } sat_type;

   function automatic sat_type sat16(input logic signed [WIDE_W-1:0] v);
      sat_type s;
      if (v > Q_MAX) begin
         s.ovf = 1'b1;
         s.val = Q_MAX[Q_W-1:0];
      end else if (v < Q_MIN) begin
         s.ovf = 1'b1;
         s.val = Q_MIN[Q_W-1:0];
      end else begin
         s.ovf = 1'b0;
         s.val = v[Q_W-1:0];
      end
      return s;
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/cau_front.sv
`default_nettype none

module cau_front (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   adv,
   input  wire logic                   in_valid,
   input  wire cau_pkg::action_type    action,
   input  wire logic signed [15:0]     a_re,
   input  wire logic signed [15:0]     a_im,
   input  wire logic signed [15:0]     b_re,
   input  wire logic signed [15:0]     b_im,
   output cau_pkg::pipe_type           pipe_out
);

   typedef struct packed {
      logic                valid;
      cau_pkg::action_type action;
      logic signed [16:0]  add_re;
      logic signed [16:0]  add_im;
      logic signed [16:0]  sub_re;
      logic signed [16:0]  sub_im;
      logic signed [31:0]  p_rr;
      logic signed [31:0]  p_ii;
      logic signed [31:0]  p_ri;
      logic signed [31:0]  p_ir;
      logic [31:0]         sq_x;
      logic [31:0]         sq_y;
   } prod_type;

   prod_type prod_in, prod_ff;
   cau_pkg::pipe_type prep_in, prep_ff;

   logic signed [15:0] sq_op_x, sq_op_y;
   logic signed [31:0] sq_px, sq_py;

   // stage 1: products, squares, and the add and subtract sums
   assign sq_op_x = (action == cau_pkg::ACT_MAG) ? a_re : b_re;
   assign sq_op_y = (action == cau_pkg::ACT_MAG) ? a_im : b_im;
   assign sq_px   = sq_op_x * sq_op_x;
   assign sq_py   = sq_op_y * sq_op_y;

   always_comb begin
      prod_in.valid  = in_valid;
      prod_in.action = action;
      prod_in.add_re = 17'(a_re) + 17'(b_re);
      prod_in.add_im = 17'(a_im) + 17'(b_im);
      prod_in.sub_re = 17'(a_re) - 17'(b_re);
      prod_in.sub_im = 17'(a_im) - 17'(b_im);
      prod_in.p_rr   = a_re * b_re;
      prod_in.p_ii   = a_im * b_im;
      prod_in.p_ri   = a_re * b_im;
      prod_in.p_ir   = a_im * b_re;
      prod_in.sq_x   = $unsigned(sq_px);
      prod_in.sq_y   = $unsigned(sq_py);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_ff.valid <= 1'b0;
      end else if (adv) begin
         prod_ff <= prod_in;
      end
   end

   // stage 2: sums, multiply rounding, saturation, divider and root setup
   logic signed [33:0] mul_re, mul_im, mul_re_t, mul_im_t, mul_re_s, mul_im_s;
   logic signed [33:0] num_re, num_im, mag_re, mag_im;
   logic [31:0]        sqsum;
   cau_pkg::sat_type   s_re, s_im;

   always_comb begin
      mul_re   = 34'(prod_ff.p_rr) - 34'(prod_ff.p_ii);
      mul_im   = 34'(prod_ff.p_ri) + 34'(prod_ff.p_ir);
      mul_re_t = (mul_re < 0) ? mul_re + 34'sd255 : mul_re;
      mul_im_t = (mul_im < 0) ? mul_im + 34'sd255 : mul_im;
      mul_re_s = mul_re_t >>> 8;
      mul_im_s = mul_im_t >>> 8;
      num_re   = 34'(prod_ff.p_rr) + 34'(prod_ff.p_ii);
      num_im   = 34'(prod_ff.p_ir) - 34'(prod_ff.p_ri);
      mag_re   = (num_re < 0) ? -num_re : num_re;
      mag_im   = (num_im < 0) ? -num_im : num_im;
      sqsum    = prod_ff.sq_x + prod_ff.sq_y;

      case (prod_ff.action)
         cau_pkg::ACT_ADD: begin
            s_re = cau_pkg::sat16(34'(prod_ff.add_re));
            s_im = cau_pkg::sat16(34'(prod_ff.add_im));
         end
         cau_pkg::ACT_SUB: begin
            s_re = cau_pkg::sat16(34'(prod_ff.sub_re));
            s_im = cau_pkg::sat16(34'(prod_ff.sub_im));
         end
         cau_pkg::ACT_MUL: begin
            s_re = cau_pkg::sat16(mul_re_s);
            s_im = cau_pkg::sat16(mul_im_s);
         end
         default: begin
            s_re = '0;
            s_im = '0;
         end
      endcase

      prep_in.valid      = prod_ff.valid;
      prep_in.action     = prod_ff.action;
      prep_in.fast_re    = s_re.val;
      prep_in.fast_im    = s_im.val;
      prep_in.fast_ovf   = s_re.ovf | s_im.ovf;
      prep_in.dz         = (prod_ff.action == cau_pkg::ACT_DIV) && (sqsum == '0);
      prep_in.neg_re     = (num_re < 0);
      prep_in.neg_im     = (num_im < 0);
      prep_in.pre_ovf_re = 1'b0;
      prep_in.pre_ovf_im = 1'b0;
      prep_in.r_re       = {mag_re[31:0], 8'b0};
      prep_in.r_im       = {mag_im[31:0], 8'b0};
      prep_in.q_re       = '0;
      prep_in.q_im       = '0;
      prep_in.den        = sqsum;
      prep_in.sq_rem     = sqsum;
      prep_in.root       = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prep_ff.valid <= 1'b0;
      end else if (adv) begin
         prep_ff <= prep_in;
      end
   end

   assign pipe_out = prep_ff;

endmodule

`default_nettype wire

>>> rtl/core/cau_step.sv
`default_nettype none

module cau_step #(
   parameter int unsigned K = 0
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              adv,
   input  wire cau_pkg::pipe_type pipe_in,
   output cau_pkg::pipe_type      pipe_out
);

   localparam int unsigned PAD_W = cau_pkg::CMP_W - cau_pkg::REM_W;

   cau_pkg::pipe_type stage_in, stage_ff;

   logic [cau_pkg::CMP_W-1:0]  den_sh;
   logic [cau_pkg::REM_W-1:0]  r_re_nx, r_im_nx;
   logic [cau_pkg::QUO_W-1:0]  q_re_nx, q_im_nx;
   logic                       pov_re_nx, pov_im_nx;
   logic [cau_pkg::SQ_W-1:0]   rem_nx;
   logic [cau_pkg::ROOT_W-1:0] root_nx;

   assign den_sh = {{cau_pkg::QUO_W{1'b0}}, pipe_in.den} << K;

   if (K == cau_pkg::QUO_W) begin : g_check
      // quotient would need more bits than kept: saturates
      assign pov_re_nx = {{PAD_W{1'b0}}, pipe_in.r_re} >= den_sh;
      assign pov_im_nx = {{PAD_W{1'b0}}, pipe_in.r_im} >= den_sh;
      assign r_re_nx   = pipe_in.r_re;
      assign r_im_nx   = pipe_in.r_im;
      assign q_re_nx   = pipe_in.q_re;
      assign q_im_nx   = pipe_in.q_im;
   end else begin : g_bit
      logic take_re, take_im;
      assign take_re   = {{PAD_W{1'b0}}, pipe_in.r_re} >= den_sh;
      assign take_im   = {{PAD_W{1'b0}}, pipe_in.r_im} >= den_sh;
      assign pov_re_nx = pipe_in.pre_ovf_re;
      assign pov_im_nx = pipe_in.pre_ovf_im;
      always_comb begin
         r_re_nx = pipe_in.r_re;
         r_im_nx = pipe_in.r_im;
         q_re_nx = pipe_in.q_re;
         q_im_nx = pipe_in.q_im;
         if (take_re) begin
            r_re_nx    = pipe_in.r_re - den_sh[cau_pkg::REM_W-1:0];
            q_re_nx[K] = 1'b1;
         end
         if (take_im) begin
            r_im_nx    = pipe_in.r_im - den_sh[cau_pkg::REM_W-1:0];
            q_im_nx[K] = 1'b1;
         end
      end
   end

   if (K < cau_pkg::ROOT_W) begin : g_root
      logic [cau_pkg::SQT_W-1:0] trial;
      logic                      fits;
      assign trial = ({{(cau_pkg::SQT_W - cau_pkg::ROOT_W){1'b0}}, pipe_in.root} << (K + 1))
                   | ({{(cau_pkg::SQT_W - 1){1'b0}}, 1'b1} << (2 * K));
      assign fits  = {2'b0, pipe_in.sq_rem} >= trial;
      always_comb begin
         rem_nx  = pipe_in.sq_rem;
         root_nx = pipe_in.root;
         if (fits) begin
            rem_nx     = pipe_in.sq_rem - trial[cau_pkg::SQ_W-1:0];
            root_nx[K] = 1'b1;
         end
      end
   end else begin : g_noroot
      assign rem_nx  = pipe_in.sq_rem;
      assign root_nx = pipe_in.root;
   end

   always_comb begin
      stage_in            = pipe_in;
      stage_in.r_re       = r_re_nx;
      stage_in.r_im       = r_im_nx;
      stage_in.q_re       = q_re_nx;
      stage_in.q_im       = q_im_nx;
      stage_in.pre_ovf_re = pov_re_nx;
      stage_in.pre_ovf_im = pov_im_nx;
      stage_in.sq_rem     = rem_nx;
      stage_in.root       = root_nx;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (adv) begin
         stage_ff <= stage_in;
      end
   end

   assign pipe_out = stage_ff;

endmodule

`default_nettype wire

>>> rtl/core/cau_back.sv
`default_nettype none

module cau_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              adv,
   input  wire cau_pkg::pipe_type pipe_in,
   output logic                   out_valid,
   output logic [15:0]            res_re,
   output logic [15:0]            res_im,
   output logic                   overflow,
   output logic                   div_zero
);

   logic               valid_ff, valid_in;
   logic [15:0]        res_re_ff, res_re_in, res_im_ff, res_im_in;
   logic               ovf_ff, ovf_in, dz_ff, dz_in;
   logic signed [33:0] qv_re, qv_im;
   cau_pkg::sat_type   d_re, d_im, m_re;

   always_comb begin
      qv_re = pipe_in.neg_re ? -34'(pipe_in.q_re) : 34'(pipe_in.q_re);
      qv_im = pipe_in.neg_im ? -34'(pipe_in.q_im) : 34'(pipe_in.q_im);
      d_re  = cau_pkg::sat16(qv_re);
      d_im  = cau_pkg::sat16(qv_im);
      if (pipe_in.pre_ovf_re) begin
         d_re.ovf = 1'b1;
         d_re.val = pipe_in.neg_re ? cau_pkg::Q_MIN[15:0] : cau_pkg::Q_MAX[15:0];
      end
      if (pipe_in.pre_ovf_im) begin
         d_im.ovf = 1'b1;
         d_im.val = pipe_in.neg_im ? cau_pkg::Q_MIN[15:0] : cau_pkg::Q_MAX[15:0];
      end
      m_re = cau_pkg::sat16(34'(pipe_in.root));

      valid_in = pipe_in.valid;
      dz_in    = pipe_in.dz;
      case (pipe_in.action)
         cau_pkg::ACT_DIV: begin
            if (pipe_in.dz) begin
               res_re_in = '0;
               res_im_in = '0;
               ovf_in    = 1'b0;
            end else begin
               res_re_in = d_re.val;
               res_im_in = d_im.val;
               ovf_in    = d_re.ovf | d_im.ovf;
            end
         end
         cau_pkg::ACT_MAG: begin
            res_re_in = m_re.val;
            res_im_in = '0;
            ovf_in    = m_re.ovf;
         end
         default: begin
            // add, subtract, multiply finished up front; unused codes carry zeros
            res_re_in = pipe_in.fast_re;
            res_im_in = pipe_in.fast_im;
            ovf_in    = pipe_in.fast_ovf;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         res_re_ff <= res_re_in;
         res_im_ff <= res_im_in;
         ovf_ff    <= ovf_in;
         dz_ff     <= dz_in;
      end
   end

   assign out_valid = valid_ff;
   assign res_re    = res_re_ff;
   assign res_im    = res_im_ff;
   assign overflow  = ovf_ff;
   assign div_zero  = dz_ff;

endmodule

`default_nettype wire

>>> rtl/core/complex_arithmetic_unit.sv
`default_nettype none

// complex arithmetic unit: add, subtract, multiply or divide two signed q8.8
// complex operands, or take the magnitude of the first one. a result word passes
// through two front stages for the products and sums, one range-check stage
// and seventeen restoring-division stages that also carry the sixteen
// square-root steps, then one output register.
// the pipeline takes one word every cycle while rsp_tready is high; when the
// output register holds a result that is not taken the whole pipeline holds.
// results are truncated toward zero and saturated to q8.8 (overflow flag);
// a divide by 0 + 0i returns zeros with the div_zero flag, and action codes
// 5 to 7 return all zeros

module complex_arithmetic_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [63:0] req_tdata,   // a_re, a_im, b_re, b_im
   input  wire logic [2:0]  req_tuser,   // action
   // response channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // res_re, res_im
   output logic [1:0]       rsp_tuser    // overflow, div_zero
);

   localparam int unsigned STEPS = cau_pkg::STEPS;

   // whole pipeline moves together, gated by the output register
   logic adv;
   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;

   cau_pkg::pipe_type chain [0:STEPS];
   logic [STEPS:0]    chain_valid;

   cau_front u_front (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_valid (req_tvalid),
      .action   (cau_pkg::action_type'(req_tuser)),
      .a_re     (req_tdata[15:0]),
      .a_im     (req_tdata[31:16]),
      .b_re     (req_tdata[47:32]),
      .b_im     (req_tdata[63:48]),
      .pipe_out (chain[0])
   );

   // step i works on quotient bit STEPS-1-i; the first one is the range check
   for (genvar i = 0; i < STEPS; i++) begin : g_step
      cau_step #(.K(STEPS - 1 - i)) u_step (
         .clock    (clock),
         .reset    (reset),
         .adv      (adv),
         .pipe_in  (chain[i]),
         .pipe_out (chain[i+1])
      );
   end

   for (genvar j = 0; j <= STEPS; j++) begin : g_valid
      assign chain_valid[j] = chain[j].valid;
   end

   logic [15:0] res_re, res_im;
   logic        overflow, div_zero;

   cau_back u_back (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .pipe_in   (chain[STEPS]),
      .out_valid (rsp_tvalid),
      .res_re    (res_re),
      .res_im    (res_im),
      .overflow  (overflow),
      .div_zero  (div_zero)
   );

   assign rsp_tdata = {res_im, res_re};
   assign rsp_tuser = {div_zero, overflow};

`ifndef SYNTHESIS
   // a zero divisor gives zero parts and no overflow
   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tdata == 32'd0 && !rsp_tuser[0])
      else $error("div_zero word with nonzero result");

   // overflow only with a part at a saturation limit
   a_ovf_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |->
         rsp_tdata[15:0] == 16'h7fff || rsp_tdata[15:0] == 16'h8000 ||
         rsp_tdata[31:16] == 16'h7fff || rsp_tdata[31:16] == 16'h8000)
      else $error("overflow flag without saturated part");

   // a held output freezes the valid flags of the front and step stages
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !req_tready |=> $stable(chain_valid))
      else $error("pipeline moved during stall");
`endif

endmodule

`default_nettype wire
